// ===== sv/saspd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis serial packet decoder package
// Character codes, packet lengths, result kinds and default sizes shared by
// the decoder.
// ----------------------------------------------------------------------------
package saspd_pkg;

    localparam int DEFAULT_PACKET_BYTES = 64;
    localparam int DEFAULT_BUTTON_COUNT = 9;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_MOTION = 8'h64;
    localparam logic [7:0] CHAR_BUTTON = 8'h6B;

    localparam int MOTION_LEN   = 26;
    localparam int BUTTON_LEN   = 5;
    localparam int AXIS_COUNT   = 6;
    localparam int NIBBLE_COUNT = 4 * AXIS_COUNT;
    localparam int MASK_BITS    = 12;

    localparam logic [15:0] AXIS_BIAS = 16'h8000;

    typedef enum logic [2:0] {
        KIND_MOTION       = 3'd0,
        KIND_BUTTON       = 3'd1,
        KIND_SHORT_MOTION = 3'd2,
        KIND_SHORT_BUTTON = 3'd3,
        KIND_OVERFLOW     = 3'd4
    } kind_t;

endpackage

// ===== sv/six_axis_serial_packet_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis serial packet decoder
// Gathers serial bytes into packets ended by a carriage return and emits
// motion, button change, short packet and overflow results.
// ----------------------------------------------------------------------------
// Each byte passes the input register; its result is registered in the result register.
// Throughput: one byte per cycle while the result register is free; a button
// packet with k changed buttons holds the input while the events drain one per
// cycle, when out_stall is low, from the result register.
// Reset clears the fill count, zero tracking, button levels and all valid
// flags at once; the captured packet bytes need no reset.
module six_axis_serial_packet_decoder_unit #(
    parameter int PACKET_BYTES = saspd_pkg::DEFAULT_PACKET_BYTES,
    parameter int BUTTON_COUNT = saspd_pkg::DEFAULT_BUTTON_COUNT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic signed [15:0] axis_x,
    output logic signed [15:0] axis_y,
    output logic signed [15:0] axis_z,
    output logic signed [15:0] rot_a,
    output logic signed [15:0] rot_b,
    output logic signed [15:0] rot_c,
    output logic [3:0]         button_number,
    output logic               button_down,
    output logic               last
);

    localparam int FILL_W = $clog2(PACKET_BYTES + 2);
    localparam int MB     = saspd_pkg::MASK_BITS;
    localparam logic [MB-1:0] BUTTON_MASK = MB'((1 << BUTTON_COUNT) - 1);
    localparam logic [FILL_W-1:0] FILL_LIMIT  = FILL_W'(PACKET_BYTES);
    localparam logic [FILL_W-1:0] MOTION_LENW = FILL_W'(saspd_pkg::MOTION_LEN);
    localparam logic [FILL_W-1:0] BUTTON_LENW = FILL_W'(saspd_pkg::BUTTON_LEN);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] byte_reg;

    // Packet state.
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              zero_seen_reg;
    logic              zero_seen_next;
    logic [FILL_W-1:0] zero_pos_reg;
    logic [FILL_W-1:0] zero_pos_next;
    logic [7:0]        first_reg;
    logic [3:0]        nib_reg [1:saspd_pkg::NIBBLE_COUNT];
    logic [MB-1:0]     buttons_reg;
    logic [MB-1:0]     buttons_next;

    // Result register.
    logic                  out_valid_reg;
    saspd_pkg::kind_t      kind_reg;
    logic signed [15:0]    axis_reg [saspd_pkg::AXIS_COUNT];
    logic [3:0]            number_reg;
    logic                  down_reg;
    logic                  last_reg;
    logic [MB-1:0]         rem_reg;
    logic [MB-1:0]         levels_reg;

    logic              advance_out;
    logic              slot_free;
    logic              process;
    logic              overflow;
    logic              packet_end;
    logic [FILL_W-1:0] text_len;
    logic              is_motion;
    logic              is_button;
    logic [MB-1:0]     new_mask;
    logic [MB-1:0]     diff;
    logic              emit_fixed;
    logic              emit_button;
    saspd_pkg::kind_t  fixed_kind;
    logic [15:0]       axis_val [saspd_pkg::AXIS_COUNT];

    logic [MB-1:0]     sel_src;
    logic [MB-1:0]     sel_levels;
    logic [MB-1:0]     sel_iso;
    logic [MB-1:0]     sel_rest;
    logic [3:0]        sel_number;

    assign advance_out = out_valid_reg && !out_stall;
    assign slot_free   = !out_valid_reg || (advance_out && (rem_reg == '0));
    assign process     = in_valid_reg && slot_free;
    assign in_stall    = in_valid_reg && !slot_free;

    assign overflow   = fill_reg > FILL_LIMIT;
    assign packet_end = !overflow && (byte_reg == saspd_pkg::CHAR_CR);
    assign text_len   = zero_seen_reg ? zero_pos_reg : fill_reg + FILL_W'(1);
    assign is_motion  = (fill_reg != '0) && (first_reg == saspd_pkg::CHAR_MOTION);
    assign is_button  = (fill_reg != '0) && (first_reg == saspd_pkg::CHAR_BUTTON);
    assign new_mask   = {nib_reg[3], nib_reg[2], nib_reg[1]};
    assign diff       = (new_mask ^ buttons_reg) & BUTTON_MASK;

    always_comb
    begin
        emit_fixed   = 1'b0;
        emit_button  = 1'b0;
        fixed_kind   = saspd_pkg::KIND_OVERFLOW;
        buttons_next = buttons_reg;
        if (overflow)
        begin
            emit_fixed = 1'b1;
        end
        else if (packet_end && is_motion)
        begin
            emit_fixed = 1'b1;
            fixed_kind = (text_len == MOTION_LENW) ? saspd_pkg::KIND_MOTION
                                                   : saspd_pkg::KIND_SHORT_MOTION;
        end
        else if (packet_end && is_button)
        begin
            if (text_len == BUTTON_LENW)
            begin
                emit_button  = diff != '0;
                buttons_next = new_mask;
            end
            else
            begin
                emit_fixed = 1'b1;
                fixed_kind = saspd_pkg::KIND_SHORT_BUTTON;
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < saspd_pkg::AXIS_COUNT; a++)
        begin
            axis_val[a] = {nib_reg[4 * a + 1], nib_reg[4 * a + 2],
                           nib_reg[4 * a + 3], nib_reg[4 * a + 4]}
                          ^ saspd_pkg::AXIS_BIAS;
        end
    end

    always_comb
    begin
        fill_next      = fill_reg + FILL_W'(1);
        zero_seen_next = zero_seen_reg;
        zero_pos_next  = zero_pos_reg;
        if (overflow || packet_end)
        begin
            fill_next      = '0;
            zero_seen_next = 1'b0;
        end
        else if ((byte_reg == 8'h00) && !zero_seen_reg)
        begin
            zero_seen_next = 1'b1;
            zero_pos_next  = fill_reg;
        end
    end

    // The lowest pending button is shown next.
    always_comb
    begin
        sel_src    = process ? diff : rem_reg;
        sel_levels = process ? new_mask : levels_reg;
        sel_iso    = sel_src & (~sel_src + MB'(1));
        sel_rest   = sel_src & ~sel_iso;
        sel_number = '0;
        for (int k = 0; k < MB; k++)
        begin
            if (sel_iso[k])
            begin
                sel_number = sel_number | 4'(k + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            zero_seen_reg <= 1'b0;
            zero_pos_reg  <= '0;
            buttons_reg   <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (process)
            begin
                fill_reg      <= fill_next;
                zero_seen_reg <= zero_seen_next;
                zero_pos_reg  <= zero_pos_next;
                buttons_reg   <= buttons_next;
            end
            if (process && emit_fixed)
            begin
                out_valid_reg <= 1'b1;
                rem_reg       <= '0;
            end
            else if (process && emit_button)
            begin
                out_valid_reg <= 1'b1;
                rem_reg       <= sel_rest;
            end
            else if (advance_out && (rem_reg != '0))
            begin
                rem_reg <= sel_rest;
            end
            else if (advance_out)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg <= rx_byte;
        end
        if (process && !overflow)
        begin
            if (fill_reg == '0)
            begin
                first_reg <= byte_reg;
            end
            for (int k = 1; k <= saspd_pkg::NIBBLE_COUNT; k++)
            begin
                if (fill_reg == FILL_W'(k))
                begin
                    nib_reg[k] <= byte_reg[3:0];
                end
            end
        end
        if (process && emit_fixed)
        begin
            kind_reg   <= fixed_kind;
            number_reg <= '0;
            down_reg   <= 1'b0;
            last_reg   <= 1'b1;
            for (int a = 0; a < saspd_pkg::AXIS_COUNT; a++)
            begin
                axis_reg[a] <= (fixed_kind == saspd_pkg::KIND_MOTION)
                               ? signed'(axis_val[a]) : 16'sd0;
            end
        end
        else if ((process && emit_button) || (advance_out && (rem_reg != '0)))
        begin
            kind_reg   <= saspd_pkg::KIND_BUTTON;
            number_reg <= sel_number;
            down_reg   <= (sel_levels & sel_iso) != '0;
            last_reg   <= sel_rest == '0;
            levels_reg <= sel_levels;
            for (int a = 0; a < saspd_pkg::AXIS_COUNT; a++)
            begin
                axis_reg[a] <= 16'sd0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign axis_x        = axis_reg[0];
    assign axis_y        = axis_reg[1];
    assign axis_z        = axis_reg[2];
    assign rot_a         = axis_reg[3];
    assign rot_b         = axis_reg[4];
    assign rot_c         = axis_reg[5];
    assign button_number = number_reg;
    assign button_down   = down_reg;
    assign last          = last_reg;

    a_rem_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> out_valid_reg)
        else $error("pending button events without a shown result");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_LIMIT + FILL_W'(1))
        else $error("fill count beyond packet limit");

    a_last_only_buttons: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (kind_reg == saspd_pkg::KIND_BUTTON))
        else $error("non-final result that is not a button event");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (rem_reg == '0)) |-> last_reg)
        else $error("final result not marked last");

endmodule
